### hdl/arp_pkg.sv
// Arpeggiator sequencer shared types and constants.
// No dependencies; used by arp_ctrl, arp_dp and arpeggiator_sequencer_core.
package arp_pkg;

  localparam int PITCH_INPUTS    = 6;
  localparam int MAX_STEP_COUNT  = 16;
  localparam int MAX_DISTANCE    = 12;
  localparam int PULSE_TICKS     = 24;
  localparam int TRIG_HOLD_TICKS = 2;
  localparam int PITCH_LIMIT     = 12000;
  localparam int SEMITONE_LSB    = 100;

  localparam logic [1:0] ORD_DOWN = 2'd0;
  localparam logic [1:0] ORD_RAND = 2'd1;
  localparam logic [1:0] ORD_UP   = 2'd2;

  localparam logic [1:0] REG_STEPS = 2'd0;
  localparam logic [1:0] REG_DIST  = 2'd1;
  localparam logic [1:0] REG_ORDER = 2'd2;
  localparam logic [1:0] REG_DIR   = 2'd3;

  localparam int IN_W  = 5 + PITCH_INPUTS + 15 * PITCH_INPUTS;
  localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;

  typedef logic signed [14:0] pitch_t;

  // controller -> datapath commands
  typedef struct packed {
    logic tick;       // evaluate control part of tick
    logic build;      // write one table entry
    logic finish;     // play and update pulse outputs
    logic [2:0] idx;  // table entry being built
  } arp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic skip;       // tick skipped, outputs held
    logic need_build; // new cycle with unlocked table
    logic [2:0] count;
  } arp_sts_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] l);
    logic b;
    b = l[0] ^ l[2] ^ l[3] ^ l[5];
    return {b, l[15:1]};
  endfunction

  // x mod n for n in 1..6; 16 = 1 mod 15, so nibble sums give x mod 15,
  // which yields mod 3 and mod 5; mod 6 combines mod 3 with the parity
  function automatic logic [2:0] mod_small(input logic [15:0] x, input logic [2:0] n);
    logic [5:0] s;
    logic [4:0] f;
    logic [3:0] r15, r3, r5;
    logic [2:0] r;
    s = 6'(x[3:0]) + 6'(x[7:4]) + 6'(x[11:8]) + 6'(x[15:12]);
    f = 5'(s[5:4]) + 5'(s[3:0]);
    r15 = (f >= 5'd15) ? 4'(f - 5'd15) : f[3:0];
    r3 = r15;
    if (r3 >= 4'd9) r3 = r3 - 4'd9;
    if (r3 >= 4'd6) r3 = r3 - 4'd6;
    if (r3 >= 4'd3) r3 = r3 - 4'd3;
    r5 = r15;
    if (r5 >= 4'd10) r5 = r5 - 4'd10;
    if (r5 >= 4'd5) r5 = r5 - 4'd5;
    case (n)
      3'd2: r = {2'b00, x[0]};
      3'd3: r = r3[2:0];
      3'd4: r = {1'b0, x[1:0]};
      3'd5: r = r5[2:0];
      3'd6: r = (r3[0] == x[0]) ? r3[2:0] : 3'(r3 + 4'd3);
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic pitch_t clamp_pitch(input logic signed [17:0] v);
    if (v > 18'sd12000) return 15'sd12000;
    if (v < -18'sd12000) return -15'sd12000;
    return v[14:0];
  endfunction

endpackage

### hdl/arp_ctrl.sv
// Arpeggiator controller: sequences the work of one tick.
// Depends on arp_pkg.
module arp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  arp_pkg::arp_sts_t   sts,
  input  logic                out_taken,
  output arp_pkg::arp_cmd_t   cmd,
  output logic                in_ready,
  output logic                out_valid
);

  typedef enum logic [2:0] {S_IDLE, S_TICK, S_BUILD, S_FINISH, S_OUT} state_t;
  state_t state;
  logic [2:0] idx;
  logic out_free, out_load;

  // output registers may only change once the previous transaction is gone
  always_comb begin
    out_free = !out_valid || out_taken;
    out_load = ((state == S_FINISH) || (state == S_OUT)) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_taken) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_fire) state <= S_TICK;
        S_TICK: begin
          idx <= '0;
          if (sts.skip) state <= S_OUT;
          else if (sts.need_build) state <= S_BUILD;
          else state <= S_FINISH;
        end
        S_BUILD: begin
          idx <= idx + 3'd1;
          if (idx + 3'd1 >= sts.count) state <= S_FINISH;
        end
        S_FINISH: if (out_free) state <= S_IDLE;
        S_OUT: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.tick = (state == S_TICK);
    cmd.build = (state == S_BUILD);
    cmd.finish = (state == S_FINISH) && out_free;
    cmd.idx = idx;
  end

  assign in_ready = (state == S_IDLE);

endmodule

### hdl/arp_dp.sv
// Arpeggiator datapath: sequence state, note table, LFSR, pulse counters.
// Depends on arp_pkg; driven by arp_ctrl commands.
module arp_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_fire,
  input  logic [arp_pkg::IN_W-1:0] in_data,
  input  logic                    cfg_fire,
  input  logic [1:0]              cfg_index,
  input  logic [4:0]              cfg_data,
  input  arp_pkg::arp_cmd_t       cmd,
  output arp_pkg::arp_sts_t       sts,
  output arp_pkg::pitch_t         pitch_out,
  output logic                    gate,
  output logic                    end_of_cycle,
  output logic                    end_of_sequence,
  output logic                    lock_lamp
);

  localparam int P = arp_pkg::PITCH_INPUTS;

  logic [4:0] step_count;
  logic [3:0] note_distance;
  logic [1:0] pitch_order, transpose_direction;

  // latched tick
  logic clk_e, trg_e, btn_e, lck_e, conn;
  arp_pkg::pitch_t packed_p [P];
  logic [2:0] count;

  logic running, free_running, locked, clocked;
  logic [4:0] steps_left, steps_done;
  logic [2:0] notes_left, note_position;
  logic signed [5:0] transpose_offset;
  logic [4:0] held_steps;
  logic [3:0] held_distance;
  logic [1:0] held_order, held_direction;
  arp_pkg::pitch_t note_table [P];
  arp_pkg::pitch_t pitch_hold;
  logic [4:0] suppress_count, gate_count, cyc_cnt, seq_cnt;
  logic [15:0] lfsr;
  logic signed [17:0] dv;

  // packing of present pitches
  arp_pkg::pitch_t pk [P];
  logic [2:0] pc;
  always_comb begin
    pc = '0;
    for (int i = 0; i < P; i++) pk[i] = '0;
    for (int i = 0; i < P; i++) begin
      if (in_data[5 + i]) begin
        pk[pc] = in_data[5 + P + 15 * i +: 15];
        pc = pc + 3'd1;
      end
    end
  end

  // control evaluation for the tick stage
  logic t_supp, t_clocked, t_locked, t_run, t_free, nc, ns, t_skip;
  logic [4:0] t_supp_cnt, t_sl, t_sd, t_cyc, t_seq, t_hs;
  logic [3:0] t_hdist;
  logic [1:0] t_ho, t_hd;
  logic [2:0] t_nl, t_np;
  logic signed [5:0] t_off;
  logic [15:0] t_lfsr;
  always_comb begin
    t_supp_cnt = suppress_count;
    if (trg_e && t_supp_cnt < 5'(arp_pkg::TRIG_HOLD_TICKS))
      t_supp_cnt = 5'(arp_pkg::TRIG_HOLD_TICKS);
    t_supp = (t_supp_cnt != 0);
    if (t_supp) t_supp_cnt = t_supp_cnt - 5'd1;
    t_locked = locked ^ lck_e;
    t_clocked = clk_e && !t_supp;
    nc = trg_e || btn_e;
    ns = nc;
    t_run = running;
    t_free = free_running;
    t_sl = steps_left;
    t_sd = steps_done;
    t_cyc = cyc_cnt;
    t_seq = seq_cnt;
    if (t_clocked && !running) begin
      if (!conn) begin
        t_free = 1'b1; ns = 1'b1; nc = 1'b1;
      end else t_free = 1'b0;
    end
    if (t_free && conn && running) t_free = 1'b0;
    if (running && t_clocked && notes_left == 0) begin
      t_sd = t_sd + 5'd1;
      t_sl = t_sl - 5'd1;
      if (t_cyc < 5'(arp_pkg::PULSE_TICKS)) t_cyc = 5'(arp_pkg::PULSE_TICKS);
      if (t_sl == 0) begin
        if (t_free) begin
          nc = 1'b1; ns = 1'b1;
        end
        t_run = 1'b0;
        if (t_seq < 5'(arp_pkg::PULSE_TICKS)) t_seq = 5'(arp_pkg::PULSE_TICKS);
      end else nc = 1'b1;
    end
    t_hs = held_steps;
    t_hdist = held_distance;
    t_ho = held_order;
    t_hd = held_direction;
    if (nc && !t_locked) begin
      t_hs = (step_count > 5'(arp_pkg::MAX_STEP_COUNT)) ?
             5'(arp_pkg::MAX_STEP_COUNT) : step_count;
      t_hdist = (note_distance > 4'(arp_pkg::MAX_DISTANCE)) ?
                4'(arp_pkg::MAX_DISTANCE) : note_distance;
      t_ho = (pitch_order == 2'd3) ? arp_pkg::ORD_UP : pitch_order;
      t_hd = (transpose_direction == 2'd3) ? arp_pkg::ORD_UP : transpose_direction;
    end
    // a new cycle with zero steps keeps only the updates above
    t_skip = nc && (t_hs == 0);
    t_off = transpose_offset;
    t_lfsr = lfsr;
    t_nl = notes_left;
    t_np = note_position;
    if (!t_skip) begin
      if (ns) begin
        t_run = 1'b1; t_sl = t_hs; t_sd = '0; t_off = '0;
      end
      if (nc) begin
        t_nl = count; t_np = '0;
        if (t_hd == arp_pkg::ORD_RAND) begin
          t_lfsr = arp_pkg::lfsr_step(lfsr);
          t_hd = t_lfsr[0] ? arp_pkg::ORD_UP : arp_pkg::ORD_DOWN;
        end
        if (t_sd != 0) begin
          if (t_hd == arp_pkg::ORD_DOWN && t_off > -6'sd31) t_off = t_off - 6'sd1;
          else if (t_hd == arp_pkg::ORD_UP && t_off < 6'sd31) t_off = t_off + 6'sd1;
        end
      end
    end
  end

  // build one entry
  logic [15:0] b_lfsr;
  logic [2:0] b_t;
  logic [2:0] b_ti;
  always_comb begin
    b_lfsr = lfsr;
    b_t = cmd.idx;
    b_ti = 3'(count - cmd.idx - 3'd1);
    unique case (held_order)
      arp_pkg::ORD_DOWN: b_t = b_ti;
      arp_pkg::ORD_RAND: begin
        b_lfsr = arp_pkg::lfsr_step(lfsr);
        b_t = arp_pkg::mod_small(b_lfsr, count);
      end
      default: b_t = cmd.idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= '0; note_distance <= '0; pitch_order <= '0;
      transpose_direction <= '0;
      running <= 1'b0; free_running <= 1'b0; locked <= 1'b0; clocked <= 1'b0;
      steps_left <= '0; steps_done <= '0; notes_left <= '0; note_position <= '0;
      transpose_offset <= '0; held_steps <= '0; held_distance <= '0;
      held_order <= '0; held_direction <= '0; pitch_hold <= '0;
      suppress_count <= '0; gate_count <= '0; cyc_cnt <= '0; seq_cnt <= '0;
      lfsr <= 16'hACE1;
      gate <= 1'b0; end_of_cycle <= 1'b0; end_of_sequence <= 1'b0;
      lock_lamp <= 1'b0; pitch_out <= '0; count <= '0; dv <= '0;
      for (int i = 0; i < P; i++) note_table[i] <= '0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          arp_pkg::REG_STEPS: step_count <= cfg_data;
          arp_pkg::REG_DIST:  note_distance <= cfg_data[3:0];
          arp_pkg::REG_ORDER: pitch_order <= cfg_data[1:0];
          default:            transpose_direction <= cfg_data[1:0];
        endcase
      end
      if (in_fire) begin
        clk_e <= in_data[0]; trg_e <= in_data[1]; btn_e <= in_data[2];
        lck_e <= in_data[3]; conn <= in_data[4];
        count <= pc;
        for (int i = 0; i < P; i++) packed_p[i] <= pk[i];
      end
      // an empty pitch mask leaves all state untouched
      if (cmd.tick && count != 3'd0) begin
        suppress_count <= t_supp_cnt; locked <= t_locked;
        free_running <= t_free; running <= t_run;
        steps_left <= t_sl; steps_done <= t_sd;
        cyc_cnt <= t_cyc; seq_cnt <= t_seq;
        held_steps <= t_hs; held_distance <= t_hdist;
        held_order <= t_ho; held_direction <= t_hd;
        lfsr <= t_lfsr; transpose_offset <= t_off;
        notes_left <= t_nl; note_position <= t_np;
        clocked <= t_clocked;
        dv <= 18'(arp_pkg::SEMITONE_LSB * $signed({1'b0, t_hdist}) * t_off);
      end
      if (cmd.build) begin
        lfsr <= b_lfsr;
        note_table[cmd.idx] <= arp_pkg::clamp_pitch(18'(packed_p[b_t]) + dv);
      end
      if (cmd.finish) begin
        logic [4:0] g;
        g = gate_count;
        if (running && clocked) begin
          if (note_position < 3'(P)) pitch_hold <= note_table[note_position];
          pitch_out <= (note_position < 3'(P)) ? note_table[note_position] : pitch_hold;
          note_position <= note_position + 3'd1;
          if (notes_left > 0) notes_left <= notes_left - 3'd1;
          if (g < 5'(arp_pkg::PULSE_TICKS)) g = 5'(arp_pkg::PULSE_TICKS);
        end else pitch_out <= pitch_hold;
        gate <= (g != 0);
        gate_count <= (g != 0) ? g - 5'd1 : g;
        end_of_cycle <= (cyc_cnt != 0);
        if (cyc_cnt != 0) cyc_cnt <= cyc_cnt - 5'd1;
        end_of_sequence <= (seq_cnt != 0);
        if (seq_cnt != 0) seq_cnt <= seq_cnt - 5'd1;
        lock_lamp <= locked;
      end
    end
  end

  always_comb begin
    sts.skip = (count == 0) || t_skip;
    sts.need_build = nc && !t_locked;
    sts.count = count;
  end

endmodule

### hdl/arpeggiator_sequencer_core.sv
// Arpeggiator sequencer top level: stream ports, controller and datapath.
// An accepted tick passes through the tick evaluation, a table build when the note
// table is rebuilt (one entry per present pitch, one entry a cycle) and the output
// update; a new tick is accepted only once the previous one is finished, and a
// result still waiting holds back the next tick's output update.
// rst is synchronous, active high; all state but the latched tick inputs clears,
// the random generator loads 0xACE1 and outputs read zero.
module arpeggiator_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // clock_edge, trigger_edge, button_edge, lock_edge, trigger_connected,
  // pitch_present[5:0], pitch_in_0..5 (15b each), zero fill
  input  logic [arp_pkg::IN_BYTES_W-1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pitch_out[14:0], gate, end_of_cycle, end_of_sequence, lock_lamp, zero fill
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  arp_pkg::arp_cmd_t cmd;
  arp_pkg::arp_sts_t sts;
  arp_pkg::pitch_t pitch_out;
  logic gate, eoc, eos, lamp, in_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  arp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .sts(sts),
    .out_taken(m_axis_tvalid && m_axis_tready), .cmd(cmd),
    .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
  );

  arp_dp u_dp (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .in_data(s_axis_tdata[arp_pkg::IN_W-1:0]),
    .cfg_fire(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts), .pitch_out(pitch_out), .gate(gate),
    .end_of_cycle(eoc), .end_of_sequence(eos), .lock_lamp(lamp)
  );

  assign m_axis_tdata = {5'd0, lamp, eos, eoc, gate, pitch_out};

endmodule
